// ===== design/assert_macros.svh =====
// Assertion macros for the mergeable stack manager.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MSM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("check failed");
`define MSM_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("check failed");
`else
`define MSM_ASSERT(lbl, clk, rst_n, prop)
`define MSM_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== design/msm_pkg.sv =====
// Shared types and constants of the mergeable stack manager.
// No dependencies.
package msm_pkg;

    localparam int NUM_STACKS_DEF = 64;
    localparam int POOL_DEPTH_DEF = 1024;
    localparam int ID_W           = 6;
    localparam int VAL_W          = 32;

    localparam logic [1:0] MODE_PUSH  = 2'd0;
    localparam logic [1:0] MODE_POP   = 2'd1;
    localparam logic [1:0] MODE_MERGE = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_VALUE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [1:0]              mode;
        logic [ID_W-1:0]         stack_id;
        logic [ID_W-1:0]         source_id;
        logic signed [VAL_W-1:0] push_value;
    } req_t;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [VAL_W-1:0] pop_value;
    } rsp_t;

    typedef struct packed {
        logic capture;
        logic node_rd;
        logic exec;
    } cmd_t;

    typedef struct packed {
        logic need_node;
    } sts_t;

endpackage

// ===== design/msm_ctrl.sv =====
// Controller of the mergeable stack manager: sequences each word and owns the handshakes.
// Depends on msm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module msm_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    input  msm_pkg::sts_t sts,
    output msm_pkg::cmd_t cmd
);
    import msm_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_NODE = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign req_stall   = (state_reg != S_IDLE);
    assign rsp_valid   = out_valid_reg;
    assign cmd.capture = req_valid && (state_reg == S_IDLE);
    assign cmd.node_rd = (state_reg == S_NODE);
    assign cmd.exec    = (state_reg == S_EXEC) && !(out_valid_reg && rsp_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = sts.need_node ? S_NODE : S_EXEC;
                end
            end
            S_NODE:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (cmd.exec)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `MSM_ASSERT(a_capture_busy, clk, rst_n, cmd.capture |=> state_reg != S_IDLE)
    `MSM_ASSERT(a_node_then_exec, clk, rst_n, cmd.node_rd |=> state_reg == S_EXEC)
    `MSM_NEVER(a_no_overwrite, clk, rst_n, cmd.exec && out_valid_reg && rsp_stall)
    `MSM_ASSERT(a_exec_valid, clk, rst_n, cmd.exec |=> rsp_valid)

endmodule

// ===== design/msm_dp.sv =====
// Datapath of the mergeable stack manager: pointer, count, node and free-list memories.
// Depends on msm_pkg; driven by msm_ctrl commands.
module msm_dp
#(
    parameter int NUM_STACKS = msm_pkg::NUM_STACKS_DEF,
    parameter int POOL_DEPTH = msm_pkg::POOL_DEPTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  msm_pkg::req_t req,
    output msm_pkg::rsp_t rsp,
    input  msm_pkg::cmd_t cmd,
    output msm_pkg::sts_t sts
);
    import msm_pkg::*;

    localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int NW = $clog2(POOL_DEPTH);
    localparam int CW = $clog2(POOL_DEPTH + 1);

    logic [NW-1:0]    top_mem   [NUM_STACKS];
    logic [NW-1:0]    bot_mem   [NUM_STACKS];
    logic [CW-1:0]    cnt_mem   [NUM_STACKS];
    logic [VAL_W-1:0] val_mem   [POOL_DEPTH];
    logic [NW-1:0]    below_mem [POOL_DEPTH];
    logic [NW-1:0]    free_mem  [POOL_DEPTH];

    logic [NUM_STACKS-1:0] cnt_vld_reg;
    logic [NUM_STACKS-1:0] cnt_vld_next;
    logic [CW-1:0]         free_count_reg;
    logic [CW-1:0]         free_count_next;
    logic [CW-1:0]         fresh_reg;
    logic [CW-1:0]         fresh_next;

    req_t             item_reg;
    rsp_t             out_reg;
    logic [NW-1:0]    top_sid_reg;
    logic [NW-1:0]    top_src_reg;
    logic [NW-1:0]    bot_src_reg;
    logic [CW-1:0]    cnt_sid_reg;
    logic [CW-1:0]    cnt_src_reg;
    logic             vld_sid_reg;
    logic             vld_src_reg;
    logic [NW-1:0]    free_top_reg;
    logic [VAL_W-1:0] nval_reg;
    logic [NW-1:0]    nbelow_reg;

    logic [SW-1:0] in_sid;
    logic [SW-1:0] in_src;
    logic [SW-1:0] sid;
    logic [SW-1:0] src;
    logic          sid_ok;
    logic          src_ok;
    logic [CW-1:0] cnt_sid;
    logic [CW-1:0] cnt_src;
    logic [NW-1:0] grab;
    rsp_t          res;

    logic             top_we;
    logic [NW-1:0]    top_wd;
    logic             bot_we;
    logic [NW-1:0]    bot_wd;
    logic             cnt_we;
    logic [CW-1:0]    cnt_wd;
    logic             val_we;
    logic             below_we;
    logic [NW-1:0]    below_wa;
    logic [NW-1:0]    below_wd;
    logic             free_we;

    assign in_sid        = SW'(req.stack_id);
    assign in_src        = SW'(req.source_id);
    assign sid           = SW'(item_reg.stack_id);
    assign src           = SW'(item_reg.source_id);
    assign sid_ok        = 32'(item_reg.stack_id) < NUM_STACKS;
    assign src_ok        = 32'(item_reg.source_id) < NUM_STACKS;
    assign cnt_sid       = vld_sid_reg ? cnt_sid_reg : '0;
    assign cnt_src       = vld_src_reg ? cnt_src_reg : '0;
    assign sts.need_node = (req.mode == MODE_POP);
    assign rsp           = out_reg;

    always_comb
    begin
        res             = '0;
        top_we          = 1'b0;
        top_wd          = '0;
        bot_we          = 1'b0;
        bot_wd          = '0;
        cnt_we          = 1'b0;
        cnt_wd          = '0;
        val_we          = 1'b0;
        below_we        = 1'b0;
        below_wa        = '0;
        below_wd        = top_sid_reg;
        free_we         = 1'b0;
        grab            = '0;
        cnt_vld_next    = cnt_vld_reg;
        free_count_next = free_count_reg;
        fresh_next      = fresh_reg;
        res.status      = ST_DONE;
        unique case (item_reg.mode)
            MODE_PUSH:
            begin
                if (sid_ok)
                begin
                    if (free_count_reg != '0 || fresh_reg < CW'(POOL_DEPTH))
                    begin
                        if (free_count_reg != '0)
                        begin
                            grab            = free_top_reg;
                            free_count_next = free_count_reg - 1'b1;
                        end
                        else
                        begin
                            grab       = fresh_reg[NW-1:0];
                            fresh_next = fresh_reg + 1'b1;
                        end
                        val_we = 1'b1;
                        if (cnt_sid == '0)
                        begin
                            bot_we = 1'b1;
                            bot_wd = grab;
                        end
                        else
                        begin
                            below_we = 1'b1;
                            below_wa = grab;
                        end
                        top_we            = 1'b1;
                        top_wd            = grab;
                        cnt_we            = 1'b1;
                        cnt_wd            = cnt_sid + 1'b1;
                        cnt_vld_next[sid] = 1'b1;
                    end
                    else
                    begin
                        res.status = ST_FULL;
                    end
                end
            end
            MODE_POP:
            begin
                if (!sid_ok || cnt_sid == '0)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    res.status    = ST_VALUE;
                    res.pop_value = nval_reg;
                    cnt_we        = 1'b1;
                    cnt_wd        = cnt_sid - 1'b1;
                    if (cnt_wd != '0)
                    begin
                        top_we = 1'b1;
                        top_wd = nbelow_reg;
                    end
                    if (free_count_reg < CW'(POOL_DEPTH))
                    begin
                        free_we         = 1'b1;
                        free_count_next = free_count_reg + 1'b1;
                    end
                end
            end
            MODE_MERGE:
            begin
                if (sid_ok && src_ok && sid != src && cnt_src != '0)
                begin
                    if (cnt_sid == '0)
                    begin
                        bot_we = 1'b1;
                        bot_wd = bot_src_reg;
                    end
                    else
                    begin
                        below_we = 1'b1;
                        below_wa = bot_src_reg;
                    end
                    top_we            = 1'b1;
                    top_wd            = top_src_reg;
                    cnt_we            = 1'b1;
                    cnt_wd            = cnt_sid + cnt_src;
                    cnt_vld_next[sid] = 1'b1;
                    cnt_vld_next[src] = 1'b0;
                end
            end
            default:
            begin
                res.status = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg     <= req;
            top_sid_reg  <= top_mem[in_sid];
            top_src_reg  <= top_mem[in_src];
            bot_src_reg  <= bot_mem[in_src];
            cnt_sid_reg  <= cnt_mem[in_sid];
            cnt_src_reg  <= cnt_mem[in_src];
            vld_sid_reg  <= cnt_vld_reg[in_sid];
            vld_src_reg  <= cnt_vld_reg[in_src];
            free_top_reg <= free_mem[NW'(free_count_reg - 1'b1)];
        end
        if (cmd.node_rd)
        begin
            nval_reg   <= val_mem[top_sid_reg];
            nbelow_reg <= below_mem[top_sid_reg];
        end
        if (cmd.exec)
        begin
            out_reg <= res;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && top_we)
        begin
            top_mem[sid] <= top_wd;
        end
        if (cmd.exec && bot_we)
        begin
            bot_mem[sid] <= bot_wd;
        end
        if (cmd.exec && cnt_we)
        begin
            cnt_mem[sid] <= cnt_wd;
        end
        if (cmd.exec && val_we)
        begin
            val_mem[grab] <= item_reg.push_value;
        end
        if (cmd.exec && below_we)
        begin
            below_mem[below_wa] <= below_wd;
        end
        if (cmd.exec && free_we)
        begin
            free_mem[free_count_reg[NW-1:0]] <= top_sid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_vld_reg    <= '0;
            free_count_reg <= '0;
            fresh_reg      <= '0;
        end
        else if (cmd.exec)
        begin
            cnt_vld_reg    <= cnt_vld_next;
            free_count_reg <= free_count_next;
            fresh_reg      <= fresh_next;
        end
    end

endmodule

// ===== design/mergeable_stack_manager_unit.sv =====
// Mergeable stack manager: several stacks kept as linked lists in one shared node pool.
// Request channel req (push, pop, merge) and response channel rsp, both valid/stall.
// A word is taken when req_valid is high and req_stall is low; one response word follows.
// Push and merge go from acceptance straight to the execute step, which loads the response
// register; pop first passes a node-read step, since the node memory is read only after the
// stack's top pointer has been read. Each memory has one registered read step and one
// write port. A new word is taken only after the previous word has executed.
// The next request is accepted the cycle after a response is loaded, even while rsp waits.
// When rsp_stall holds a response, the following word finishes its reads and then waits
// before writing until the held response is taken.
// Reset clears the per-stack valid bits (all stacks empty), the free list count and the
// fresh node counter; no clearing pass runs, so requests are taken right after reset.
// Status: done, value, stack empty, pool full; pop_value is zero unless a value is popped.
module mergeable_stack_manager_unit
#(
    parameter int NUM_STACKS = msm_pkg::NUM_STACKS_DEF,
    parameter int POOL_DEPTH = msm_pkg::POOL_DEPTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  msm_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output msm_pkg::rsp_t rsp
);
    import msm_pkg::*;

    cmd_t cmd;
    sts_t sts;

    msm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    msm_dp
    #(
        .NUM_STACKS (NUM_STACKS),
        .POOL_DEPTH (POOL_DEPTH)
    )
    u_dp
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .sts   (sts)
    );

endmodule

// ===== tb/sv/tb_mergeable_stack_manager_unit.sv =====
`timescale 1ns / 1ps
// Testbench for mergeable_stack_manager_unit: directed and random push/pop/merge words,
// checked against a scoreboard that tracks its own copy of the stacks and node pool.
// Depends on msm_pkg and the RTL only.
module tb_mergeable_stack_manager_unit;
    import msm_pkg::*;

    localparam int STACKS = NUM_STACKS_DEF;
    localparam int POOL   = POOL_DEPTH_DEF;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    class stack_scoreboard;
        logic [9:0]  top_node[STACKS];
        logic [9:0]  bottom_node[STACKS];
        int          depth[STACKS];
        logic [31:0] node_val[POOL];
        logic [9:0]  node_next[POOL];
        logic [9:0]  free_nodes[POOL];
        int          free_cnt;
        int          fresh_cnt;
        int          full_hits;
        int          errors;
        rsp_t        pending[$];

        function new();
            foreach (depth[i]) depth[i] = 0;
            free_cnt  = 0;
            fresh_cnt = 0;
            full_hits = 0;
            errors    = 0;
        endfunction

        function void note_word(req_t w);
            rsp_t       r;
            logic [9:0] n;
            int         s;
            int         src;
            r.status    = ST_DONE;
            r.pop_value = '0;
            s   = w.stack_id;
            src = w.source_id;
            if (w.mode == MODE_PUSH)
            begin
                if (free_cnt > 0)
                begin
                    free_cnt--;
                    n = free_nodes[free_cnt];
                end
                else if (fresh_cnt < POOL)
                begin
                    n = fresh_cnt[9:0];
                    fresh_cnt++;
                end
                else
                begin
                    r.status = ST_FULL;
                    full_hits++;
                end
                if (r.status != ST_FULL)
                begin
                    node_val[n] = w.push_value;
                    if (depth[s] == 0)
                        bottom_node[s] = n;
                    else
                        node_next[n] = top_node[s];
                    top_node[s] = n;
                    depth[s]++;
                end
            end
            else if (w.mode == MODE_POP)
            begin
                if (depth[s] == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    n = top_node[s];
                    r.status    = ST_VALUE;
                    r.pop_value = node_val[n];
                    depth[s]--;
                    if (depth[s] != 0)
                        top_node[s] = node_next[n];
                    free_nodes[free_cnt] = n;
                    free_cnt++;
                end
            end
            else if (w.mode == MODE_MERGE)
            begin
                if (s != src && depth[src] != 0)
                begin
                    if (depth[s] == 0)
                        bottom_node[s] = bottom_node[src];
                    else
                        node_next[bottom_node[src]] = top_node[s];
                    top_node[s] = top_node[src];
                    depth[s] += depth[src];
                    depth[src] = 0;
                end
            end
            pending.push_back(r);
        endfunction

        function void check_word(rsp_t got);
            rsp_t exp_r;
            if (pending.size() == 0)
            begin
                $display("%0t: response with none expected: status %0d value %0d",
                         $time, got.status, got.pop_value);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.status !== exp_r.status)
            begin
                $display("%0t: status expected %0d actual %0d",
                         $time, exp_r.status, got.status);
                errors++;
            end
            if (got.pop_value !== exp_r.pop_value)
            begin
                $display("%0t: pop_value expected %0d actual %0d",
                         $time, exp_r.pop_value, got.pop_value);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    stack_scoreboard sb;
    int              rsp_taken;
    int              idle_cycles;

    mergeable_stack_manager_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int gap_len();
        if ($urandom_range(9) < 5)
            return 0;
        if ($urandom_range(19) == 0)
            return $urandom_range(40, 15);
        return $urandom_range(3, 1);
    endfunction

    function automatic logic [5:0] pick_stack();
        if ($urandom_range(3) == 0)
            return 6'($urandom_range(63));
        return 6'($urandom_range(7));
    endfunction

    task automatic send_word(input logic [1:0] m, input logic [5:0] s,
                             input logic [5:0] src, input logic [31:0] v,
                             input bit use_gaps);
        int g;
        g = use_gaps ? gap_len() : 0;
        if (g > 0)
        begin
            req_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        req_valid      <= 1'b1;
        req.mode       <= m;
        req.stack_id   <= s;
        req.source_id  <= src;
        req.push_value <= v;
        do
            @(posedge clk);
        while (!(req_valid && !req_stall));
    endtask

    task automatic send_random(input int push_pct, input int pop_pct);
        int          r;
        logic [1:0]  m;
        r = $urandom_range(99);
        if (r < push_pct)
            m = MODE_PUSH;
        else if (r < push_pct + pop_pct)
            m = MODE_POP;
        else if (r < 97)
            m = MODE_MERGE;
        else
            m = MODE_UNUSED;
        send_word(m, pick_stack(), pick_stack(), $urandom(), 1'b1);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                sb.note_word(req);
            if (rsp_valid && !rsp_stall)
                sb.check_word(rsp);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= 5000)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int  g;
        bit  held;
        rsp_stall = 1'b0;
        rsp_taken = 0;
        held      = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
                rsp_taken++;
            if (!held && rsp_taken >= 300)
            begin
                held = 1;
                rsp_stall <= 1'b1;
                repeat (400) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            else if (rsp_taken > 600 && rsp_taken < 700)
            begin
                rsp_stall <= 1'b0;
            end
            else
            begin
                g = gap_len();
                rsp_stall <= (g > 0);
                if (g > 1)
                    repeat (g - 1) @(posedge clk);
            end
        end
    end

    initial
    begin
        int n;
        sb        = new();
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(MODE_POP,    6'd0,  6'd0,  32'd0,         1'b0);
        send_word(MODE_PUSH,   6'd0,  6'd63, 32'h8000_0000, 1'b0);
        send_word(MODE_PUSH,   6'd0,  6'd0,  32'h7FFF_FFFF, 1'b0);
        send_word(MODE_PUSH,   6'd63, 6'd0,  32'hFFFF_FFFF, 1'b0);
        send_word(MODE_PUSH,   6'd63, 6'd0,  32'd0,         1'b0);
        send_word(MODE_MERGE,  6'd5,  6'd9,  32'hFFFF_FFFF, 1'b0);
        send_word(MODE_MERGE,  6'd0,  6'd0,  32'd0,         1'b0);
        send_word(MODE_MERGE,  6'd0,  6'd63, 32'd0,         1'b0);
        send_word(MODE_MERGE,  6'd7,  6'd0,  32'd0,         1'b0);
        send_word(MODE_UNUSED, 6'd7,  6'd7,  32'h1234_5678, 1'b0);
        send_word(MODE_PUSH,   6'd3,  6'd0,  32'd42,        1'b0);
        send_word(MODE_MERGE,  6'd3,  6'd7,  32'd0,         1'b0);
        send_word(MODE_POP,    6'd63, 6'd0,  32'd0,         1'b0);
        send_word(MODE_PUSH,   6'd7,  6'd0,  32'h5A5A_A5A5, 1'b0);
        repeat (7) send_word(MODE_POP, 6'd3, 6'd0, 32'd0, 1'b0);
        send_word(MODE_POP,    6'd7,  6'd0,  32'd0,         1'b0);
        send_word(MODE_POP,    6'd7,  6'd0,  32'd0,         1'b0);

        for (n = 0; n < 60; n++)
            send_random(40, 35);
        n = 0;
        while (sb.full_hits < 10 && n < 1500)
        begin
            send_random(95, 3);
            n++;
        end
        for (n = 0; n < 80; n++)
            send_random(25, 55);

        @(posedge clk);
        req_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== mergeable_stack_manager_unit.f =====
+incdir+design
design/msm_pkg.sv
design/msm_ctrl.sv
design/msm_dp.sv
design/mergeable_stack_manager_unit.sv
tb/sv/tb_mergeable_stack_manager_unit.sv
